// ===== design/fwrbv_pkg.sv =====
// Shared types, constants and helpers for the FIFO with remove-by-value.
`timescale 1ns / 1ps

package fwrbv_pkg;

  // Store depth; a power of two so that slot arithmetic wraps by truncation.
  localparam int QUEUE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int DATA_W      = 32;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    REQ_ENQ = 2'd0,
    REQ_DEQ = 2'd1,
    REQ_REM = 2'd2,
    REQ_NOP = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } stat_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DEQ    = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_SHIFT  = 4'b1000
  } state_t;

  // Physical slot of the entry at a given offset from the head.
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [CNT_W-1:0] pos);
    return IDX_W'(head + pos[IDX_W-1:0]);
  endfunction

endpackage

// ===== design/fwrbv_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps

module fwrbv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/fifo_with_remove_by_value.sv =====
// Top level: circular FIFO of signed 32-bit values with remove-by-value.
//
//   channel | ports                                    | handshake
//   --------+------------------------------------------+---------------------------
//   request | in_req_type, in_value                    | beat taken when start && !busy
//   result  | out_data_out, out_status, out_occupancy  | beat on the cycle out_valid is high
//
// Enqueue answers in the cycle after the request beat; a dequeue pops in ST_DEQ.
// Remove walks the store through the single read port, one entry per cycle,
// then slides the later entries down one slot per cycle; the port sets the pace.
// Reset clears head, count and the sequencer; store contents stay undefined.
// The result beat cannot be stalled; busy holds off new requests meanwhile.
`timescale 1ns / 1ps

module fifo_with_remove_by_value
  import fwrbv_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_req_type,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_data_out,
  output logic [1:0]               out_status,
  output logic [CNT_W-1:0]         out_occupancy
);

  state_t                   state_r, state_nxt;
  logic [IDX_W-1:0]         head_r, head_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  // Search pipeline: rd_pos is the next offset to read, pend_pos the offset
  // whose data returns from the RAM this cycle.
  logic [CNT_W-1:0]         rd_pos_r, rd_pos_nxt;
  logic [CNT_W-1:0]         pend_pos_r, pend_pos_nxt;
  logic                     pend_r, pend_nxt;
  // Compaction: offset being overwritten by its successor.
  logic [CNT_W-1:0]         k_r, k_nxt;
  logic [DATA_W-1:0]        target_r, target_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]        out_data_r, out_data_nxt;
  stat_t                    out_status_r, out_status_nxt;
  logic [CNT_W-1:0]         out_occ_r, out_occ_nxt;

  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  logic [DATA_W-1:0]        wr_data;
  logic [IDX_W-1:0]         rd_addr;
  logic [DATA_W-1:0]        rd_data;

  logic                     accept;
  logic [CNT_W-1:0]         count_inc;
  logic [CNT_W-1:0]         count_dec;
  logic [CNT_W-1:0]         pend_next_pos;
  logic [CNT_W-1:0]         k_next_pos;
  logic [CNT_W-1:0]         k_read_pos;

  assign busy          = (state_r != ST_IDLE);
  assign accept        = start && !busy;
  assign count_inc     = CNT_W'(count_r + 1'b1);
  assign count_dec     = CNT_W'(count_r - 1'b1);
  assign pend_next_pos = CNT_W'(pend_pos_r + 1'b1);
  assign k_next_pos    = CNT_W'(k_r + 1'b1);
  assign k_read_pos    = CNT_W'(k_r + 2'd2);

  fwrbv_ram #(
    .WIDTH (DATA_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    rd_pos_nxt     = rd_pos_r;
    pend_pos_nxt   = pend_pos_r;
    pend_nxt       = pend_r;
    k_nxt          = k_r;
    target_nxt     = target_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_occ_nxt    = out_occ_r;
    wr_en          = 1'b0;
    wr_addr        = slot_of(head_r, count_r);
    wr_data        = in_value;
    rd_addr        = head_r;

    unique case (state_r)
      ST_IDLE: begin
        // The head read is issued every idle cycle; a dequeue picks it up next.
        if (accept) begin
          target_nxt = in_value;
          unique case (req_t'(in_req_type))
            REQ_ENQ: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
              if (count_r == DEPTH_CNT) begin
                // Refuse: store full, state unchanged.
                out_status_nxt = STAT_FULL;
                out_occ_nxt    = count_r;
              end else begin
                wr_en          = 1'b1;
                count_nxt      = count_inc;
                out_status_nxt = STAT_OK;
                out_occ_nxt    = count_inc;
              end
            end
            REQ_DEQ: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_data_nxt   = '0;
                out_status_nxt = STAT_EMPTY;
                out_occ_nxt    = count_r;
              end else begin
                state_nxt = ST_DEQ;
              end
            end
            REQ_REM: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_data_nxt   = '0;
                out_status_nxt = STAT_NOT_FOUND;
                out_occ_nxt    = count_r;
              end else begin
                rd_pos_nxt = '0;
                pend_nxt   = 1'b0;
                state_nxt  = ST_SEARCH;
              end
            end
            default: begin
              // Unused request code: answer without touching the queue.
              out_valid_nxt  = 1'b1;
              out_data_nxt   = '0;
              out_status_nxt = STAT_OK;
              out_occ_nxt    = count_r;
            end
          endcase
        end
      end

      ST_DEQ: begin
        // Head data is back from the RAM: pop it.
        out_valid_nxt  = 1'b1;
        out_data_nxt   = rd_data;
        out_status_nxt = STAT_OK;
        out_occ_nxt    = count_dec;
        head_nxt       = IDX_W'(head_r + 1'b1);
        count_nxt      = count_dec;
        state_nxt      = ST_IDLE;
      end

      ST_SEARCH: begin
        // Keep one read in flight; rd_pos is always pend_pos + 1 once pending,
        // so on a hit the successor of the match is already on its way.
        rd_addr = slot_of(head_r, rd_pos_r);
        if (pend_r && (rd_data == target_r)) begin
          k_nxt     = pend_pos_r;
          state_nxt = ST_SHIFT;
        end else if (pend_r && (pend_next_pos >= count_r)) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = '0;
          out_status_nxt = STAT_NOT_FOUND;
          out_occ_nxt    = count_r;
          state_nxt      = ST_IDLE;
        end else begin
          pend_nxt     = 1'b1;
          pend_pos_nxt = rd_pos_r;
          rd_pos_nxt   = CNT_W'(rd_pos_r + 1'b1);
        end
      end

      ST_SHIFT: begin
        // rd_data holds entry k+1: move it down to k, fetch k+2.
        rd_addr = slot_of(head_r, k_read_pos);
        if (k_next_pos < count_r) begin
          wr_en   = 1'b1;
          wr_addr = slot_of(head_r, k_r);
          wr_data = rd_data;
          k_nxt   = k_next_pos;
        end else begin
          // Drop the last slot; this also pulls the tail back by one.
          count_nxt      = count_dec;
          out_valid_nxt  = 1'b1;
          out_data_nxt   = '0;
          out_status_nxt = STAT_OK;
          out_occ_nxt    = count_dec;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    rd_pos_r     <= rd_pos_nxt;
    pend_pos_r   <= pend_pos_nxt;
    k_r          <= k_nxt;
    target_r     <= target_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_data_out  = out_data_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occ_r;

endmodule

// ===== design/fwrbv_checker.sv =====
// Port-level checker for the FIFO with remove-by-value, bound to the top level.
`timescale 1ns / 1ps

module fwrbv_checker
  import fwrbv_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic [1:0]               in_req_type,
  input logic signed [DATA_W-1:0] in_value,
  input logic                     out_valid,
  input logic signed [DATA_W-1:0] out_data_out,
  input logic [1:0]               out_status,
  input logic [CNT_W-1:0]         out_occupancy
);

  // An enqueue answers on the very next cycle, either ok or full.
  a_enq_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req_type == REQ_ENQ)) |=>
      (out_valid && ((out_status == STAT_OK) || (out_status == STAT_FULL))))
    else $error("enqueue beat not answered next cycle");

  // Leaving a multi-cycle operation always comes with its result beat.
  a_busy_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result beat");

  // Failed requests carry zero data.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STAT_OK)) |-> (out_data_out == '0))
    else $error("non-ok result with nonzero data");

  // Occupancy never exceeds the store.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_occupancy <= DEPTH_CNT))
    else $error("occupancy above depth");

  // A full refusal reports a full store.
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STAT_FULL)) |-> (out_occupancy == DEPTH_CNT))
    else $error("full status with store not full");

endmodule

bind fifo_with_remove_by_value fwrbv_checker u_fwrbv_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_req_type   (in_req_type),
  .in_value      (in_value),
  .out_valid     (out_valid),
  .out_data_out  (out_data_out),
  .out_status    (out_status),
  .out_occupancy (out_occupancy)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the FIFO with remove-by-value.
`timescale 1ns / 1ps

module tb_top;
  import fwrbv_pkg::*;

  // Stimulus sizes. The deep phase builds a long queue, runs long removes and drains it.
  localparam int RAND_ITEMS  = 300;
  localparam int CALM_ITEMS  = 80;    // tail of the random part with no idling
  localparam int DEEP_FILL   = 120;   // occupancy reached in the deep phase
  localparam int MAX_ITEMS   = 800;   // upper bound on all requests sent
  // Worst case per request: a remove over a full store plus the longest idle burst.
  localparam int CYCLE_LIMIT = 3 * MAX_ITEMS * (QUEUE_DEPTH + 12);
  localparam int SHOW_LIMIT  = 10;

  localparam logic signed [DATA_W-1:0] TAIL_MARK = 32'sh0F1E2D3C;
  localparam logic signed [DATA_W-1:0] PALETTE [12] = '{
    32'sh0000_0000, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1, 32'sd2,
    32'sd3, 32'sd5, 32'sd8, 32'sd13, 32'sd100, -32'sd100
  };

  typedef struct {
    logic signed [DATA_W-1:0] data;
    stat_t                    status;
    logic [CNT_W-1:0]         occ;
  } answer_t;

  // Shadow copy of the queue plus the answers still owed by the block.
  class fifo_scoreboard;
    logic signed [DATA_W-1:0] slots [QUEUE_DEPTH];
    logic [IDX_W-1:0]         head;
    logic [CNT_W-1:0]         count;
    answer_t                  owed_answers [$];
    int                       mismatches;
    int                       answers_checked;
    int                       peak_occ;
    int                       kinds_seen [4];
    int                       status_seen [4];

    function new();
      head            = '0;
      count           = '0;
      mismatches      = 0;
      answers_checked = 0;
      peak_occ        = 0;
      foreach (kinds_seen[k]) kinds_seen[k] = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
    endfunction

    function logic signed [DATA_W-1:0] entry_at(int offset);
      return slots[IDX_W'(head + offset)];
    endfunction

    // Offset from the head of the first entry equal to value, or -1.
    function int find(logic signed [DATA_W-1:0] value);
      for (int k = 0; k < count; k++) begin
        if (entry_at(k) == value) return k;
      end
      return -1;
    endfunction

    function void note_request(req_t kind, logic signed [DATA_W-1:0] value);
      answer_t ans;
      int      pos;
      ans.data   = '0;
      ans.status = STAT_OK;
      case (kind)
        REQ_ENQ: begin
          if (count == DEPTH_CNT) begin
            ans.status = STAT_FULL;
          end else begin
            slots[IDX_W'(head + count)] = value;
            count++;
          end
        end
        REQ_DEQ: begin
          if (count == 0) begin
            ans.status = STAT_EMPTY;
          end else begin
            ans.data = slots[head];
            head++;
            count--;
          end
        end
        REQ_REM: begin
          pos = find(value);
          if (pos < 0) begin
            ans.status = STAT_NOT_FOUND;
          end else begin
            // close the gap: later entries slide one slot toward the head
            for (int k = pos; k + 1 < count; k++) slots[IDX_W'(head + k)] = entry_at(k + 1);
            count--;
          end
        end
        default: ;
      endcase
      ans.occ = count;
      owed_answers.push_back(ans);
      kinds_seen[kind]++;
      if (count > peak_occ) peak_occ = count;
    endfunction

    function void check_result(logic signed [DATA_W-1:0] data, logic [1:0] status,
                               logic [CNT_W-1:0] occ);
      answer_t want;
      answers_checked++;
      if (owed_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("result %0d with no request outstanding: data %0d status %0d occ %0d",
                   answers_checked, data, status, occ);
        return;
      end
      want = owed_answers.pop_front();
      status_seen[want.status]++;
      if (data !== want.data || status !== want.status || occ !== want.occ) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display({"result %0d: expected data %0d status %0d occupancy %0d, ",
                    "got data %0d status %0d occupancy %0d"},
                   answers_checked, want.data, want.status, want.occ, data, status, occ);
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               in_req_type = REQ_NOP;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_data_out;
  logic [1:0]               out_status;
  logic [CNT_W-1:0]         out_occupancy;

  fifo_scoreboard sb;
  int             cycles = 0;
  bit             idling_on = 1'b1;

  fifo_with_remove_by_value uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_data_out  (out_data_out),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Sample both channels at the rising edge. Check the result beat first: it
  // belongs to an earlier request, never to one accepted at this same edge.
  always @(posedge clk) begin
    cycles++;
    if (rst_n) begin
      if (out_valid) sb.check_result(out_data_out, out_status, out_occupancy);
      if (start && !busy) sb.note_request(req_t'(in_req_type), in_value);
    end
  end

  // Watchdog: end the run if the block stops answering.
  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d answers still owed", cycles,
             sb.owed_answers.size());
    $display("simulation failed");
    $finish;
  end

  // Present one request beat and hold it until the block takes it.
  task automatic send(input req_t kind, input logic signed [DATA_W-1:0] value);
    @(negedge clk);
    start       <= 1'b1;
    in_req_type <= kind;
    in_value    <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start for a few cycles; wiggle the payload so stale data is ignored.
  task automatic idle_for(input int n);
    repeat (n) begin
      @(negedge clk);
      start       <= 1'b0;
      in_req_type <= 2'($urandom);
      in_value    <= $urandom;
    end
  endtask

  task automatic maybe_idle();
    if (idling_on && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 5));
  endtask

  // Hold off new requests until every owed answer has come back.
  task automatic wait_for_answers();
    @(negedge clk);
    start <= 1'b0;
    while (sb.owed_answers.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 9) < 6) return PALETTE[$urandom_range(0, 11)];
    return $urandom;
  endfunction

  // Remove targets mostly hit a held entry at a random depth; the rest miss or
  // land on duplicates from the palette.
  function automatic logic signed [DATA_W-1:0] pick_target();
    if (sb.count != 0 && $urandom_range(0, 99) < 65)
      return sb.entry_at($urandom_range(0, sb.count - 1));
    return pick_value();
  endfunction

  // Short hand-picked sequence: empty-queue errors, the idle request type,
  // extreme values, duplicates, removal at head, middle and tail.
  task automatic run_directed();
    send(REQ_DEQ, 32'sd0);            // dequeue from empty
    send(REQ_REM, 32'sd0);            // remove from empty
    send(REQ_NOP, $urandom);
    send(REQ_ENQ, 32'sh7FFF_FFFF);
    send(REQ_ENQ, 32'sh8000_0000);
    send(REQ_ENQ, 32'sd0);
    send(REQ_ENQ, -32'sd1);
    send(REQ_ENQ, 32'sd5);
    send(REQ_ENQ, 32'sd5);
    send(REQ_REM, 32'sd5);            // first of two duplicates
    send(REQ_REM, 32'sd123);          // no match
    send(REQ_REM, 32'sd5);            // tail entry
    send(REQ_ENQ, 32'sd7);            // lands where the removed tail was
    send(REQ_DEQ, 32'sd0);
    send(REQ_REM, 32'sh8000_0000);    // head entry
    send(REQ_NOP, -32'sd1);
    send(REQ_DEQ, 32'sh7FFF_FFFF);    // value ignored on dequeue
    send(REQ_DEQ, 32'sd0);
    send(REQ_DEQ, 32'sd0);
    send(REQ_DEQ, 32'sd0);            // empty again
    send(REQ_ENQ, 32'sh5555_5555);
    send(REQ_ENQ, 32'shAAAA_AAAA);
    send(REQ_REM, 32'shAAAA_AAAA);    // tail of two
    send(REQ_REM, 32'sh5555_5555);    // sole entry
    send(REQ_REM, 32'sh5555_5555);
  endtask

  // Build a deep queue with the head off slot zero, run long removes at the
  // head, middle and tail plus a full search with no match, then drain.
  task automatic run_deep_queue();
    logic signed [DATA_W-1:0] absent;
    while (sb.count < DEEP_FILL - 1) begin
      send(REQ_ENQ, ($urandom_range(0, 7) == 0) ? pick_value() : $urandom);
      maybe_idle();
    end
    send(REQ_ENQ, TAIL_MARK);
    send(REQ_NOP, $urandom);
    send(REQ_REM, TAIL_MARK);         // tail of a deep queue
    send(REQ_ENQ, TAIL_MARK);
    send(REQ_REM, sb.entry_at(0));
    send(REQ_REM, sb.entry_at(DEEP_FILL / 2));
    absent = $urandom;
    while (sb.find(absent) >= 0) absent = $urandom;
    send(REQ_REM, absent);            // full search, no match
    while (sb.count != 0) begin
      send(REQ_DEQ, $urandom);
      maybe_idle();
    end
    send(REQ_DEQ, $urandom);
  endtask

  task automatic run_random();
    int   roll;
    int   enq_pct;
    req_t kind;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      idling_on = (i < RAND_ITEMS - CALM_ITEMS);
      // let the pipeline run dry now and then, and once for certain mid-run
      if (i == RAND_ITEMS / 2 || (idling_on && $urandom_range(0, 49) == 0))
        wait_for_answers();
      // steer occupancy: grow from near empty, shrink once removes get long
      enq_pct = (sb.count < 4) ? 60 : (sb.count > 48) ? 25 : 45;
      roll    = $urandom_range(0, 99);
      if (roll < enq_pct) kind = REQ_ENQ;
      else if (roll < enq_pct + (95 - enq_pct) / 2) kind = REQ_DEQ;
      else if (roll < 95) kind = REQ_REM;
      else kind = REQ_NOP;
      case (kind)
        REQ_ENQ: send(kind, pick_value());
        REQ_REM: send(kind, pick_target());
        default: send(kind, $urandom);
      endcase
      maybe_idle();
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    wait_for_answers();
    run_deep_queue();
    wait_for_answers();
    run_random();

    // Drain, then leave room for any stray late beat.
    wait_for_answers();
    repeat (QUEUE_DEPTH + 8) @(posedge clk);

    $display("requests: %0d enqueue, %0d dequeue, %0d remove, %0d no-op; peak occupancy %0d",
             sb.kinds_seen[REQ_ENQ], sb.kinds_seen[REQ_DEQ], sb.kinds_seen[REQ_REM],
             sb.kinds_seen[REQ_NOP], sb.peak_occ);
    $display("answers: %0d ok, %0d empty, %0d full, %0d not found; %0d mismatches",
             sb.status_seen[STAT_OK], sb.status_seen[STAT_EMPTY], sb.status_seen[STAT_FULL],
             sb.status_seen[STAT_NOT_FOUND], sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== fifo_with_remove_by_value.f =====
design/fwrbv_pkg.sv
design/fwrbv_ram.sv
design/fifo_with_remove_by_value.sv
design/fwrbv_checker.sv
verif/tb_top.sv
